@@ rtl/utf8sd_pkg.sv @@
// Package of constants, the result record type and the lead-byte helper for the UTF-8 decoder.
package utf8sd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  CONT_MASK  = 8'hC0;
   localparam logic [7:0]  CONT_TAG   = 8'h80;
   localparam logic [5:0]  PAYLOAD6   = 6'h3F;
   localparam logic [6:0]  PAYLOAD7   = 7'h7F;
   localparam logic [31:0] ERROR_MARK = 32'h0000_005E;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            bad_sequence;
      logic            last_of_run;
   } result_type;

   // Count of leading one bits of a byte, 0 to 8.
   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      casez (b)
         8'b0???_????: n = 4'd0;
         8'b10??_????: n = 4'd1;
         8'b110?_????: n = 4'd2;
         8'b1110_????: n = 4'd3;
         8'b1111_0???: n = 4'd4;
         8'b1111_10??: n = 4'd5;
         8'b1111_110?: n = 4'd6;
         8'b1111_1110: n = 4'd7;
         default:      n = 4'd8;
      endcase
      return n;
   endfunction

endpackage

@@ rtl/utf8_stream_decoder_core.sv @@
// Byte-serial UTF-8 decoder: input register, single-pass decode and a small result queue.
// Each accepted byte is decoded from the input register into the result queue, and its
// first result is offered on rsp_ from there. Throughput: one byte per cycle while each
// byte yields at most one result and rsp_stall is low; a broken sequence can yield two, and
// input is held back while the four-entry queue has under two free entries. Synchronous
// reset clears the open sequence, input valid flag and queue; no result is offered.
module utf8_stream_decoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [utf8sd_pkg::BYTE_W-1:0]  req_byte_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [utf8sd_pkg::CP_W-1:0]    rsp_code_point,
   output logic                           rsp_bad_sequence,
   output logic                           rsp_last_of_run
);
   import utf8sd_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff, in_byte_in;
   logic [2:0]            pend_ff, pend_in;
   logic [CP_W-1:0]       part_ff, part_in;
   result_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     head_ff, head_in;
   logic [QPTR_W-1:0]     tail_ff, tail_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   logic                  advance;
   logic                  pop;
   logic                  fresh;
   logic [1:0]            res_cnt;
   result_type            res [2];
   logic [3:0]            n_ones;
   logic [CP_W-1:0]       acc;
   logic [BYTE_W-1:0]     b;
   logic [QPTR_W-1:0]     tail_next;

   // Room for the two results a byte can cause must be free before it is decoded.
   assign advance   = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   assign rsp_code_point   = queue_ff[head_ff].code_point;
   assign rsp_bad_sequence = queue_ff[head_ff].bad_sequence;
   assign rsp_last_of_run  = queue_ff[head_ff].last_of_run;

   assign b         = in_byte_ff;
   assign n_ones    = lead_ones(b);
   assign acc       = {part_ff[CP_W-7:0], b[5:0] & PAYLOAD6};
   assign tail_next = tail_ff + QPTR_W'(1);

   always_comb begin
      in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
      in_byte_in  = (req_valid && !req_stall) ? req_byte_in : in_byte_ff;
      pend_in     = pend_ff;
      part_in     = part_ff;
      res_cnt     = 2'd0;
      fresh       = 1'b1;
      res[0]      = '0;
      res[1]      = '0;

      if (in_valid_ff && advance) begin
         if (pend_ff != 3'd0) begin
            if ((b & CONT_MASK) == CONT_TAG) begin
               fresh   = 1'b0;
               part_in = acc;
               pend_in = pend_ff - 3'd1;
               if (pend_ff == 3'd1) begin
                  res[0]  = '{code_point: acc, bad_sequence: 1'b0, last_of_run: 1'b0};
                  res_cnt = 2'd1;
               end
            end else begin
               res[0]  = '{code_point: ERROR_MARK, bad_sequence: 1'b1, last_of_run: 1'b0};
               res_cnt = 2'd1;
               pend_in = 3'd0;
            end
         end

         // A byte that breaks a sequence is decoded again as a new byte.
         if (fresh) begin
            if (n_ones == 4'd0) begin
               res[res_cnt[0]] = '{code_point: CP_W'(b), bad_sequence: 1'b0,
                                   last_of_run: 1'b0};
               res_cnt = res_cnt + 2'd1;
            end else if (n_ones == 4'd1) begin
               res[res_cnt[0]] = '{code_point: CP_W'(b[6:0] & PAYLOAD7), bad_sequence: 1'b0,
                                   last_of_run: 1'b0};
               res_cnt = res_cnt + 2'd1;
            end else begin
               part_in = CP_W'(b & (8'hFF >> n_ones));
               pend_in = 3'(n_ones - 4'd1);
            end
         end

         if (res_cnt == 2'd1) begin
            res[0].last_of_run = 1'b1;
         end else if (res_cnt == 2'd2) begin
            res[1].last_of_run = 1'b1;
         end
      end

      head_in  = pop ? head_ff + QPTR_W'(1) : head_ff;
      tail_in  = tail_ff + QPTR_W'(res_cnt);
      count_in = count_ff + QCNT_W'(res_cnt) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pend_ff     <= 3'd0;
         part_ff     <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pend_ff     <= pend_in;
         part_ff     <= part_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (res_cnt != 2'd0) begin
         queue_ff[tail_ff] <= res[0];
      end
      if (res_cnt == 2'd2) begin
         queue_ff[tail_next] <= res[1];
      end
   end

endmodule
